### src/hsfc_pkg.sv
// ----------------------------------------------------------------------------
// hsfc_pkg: shared types and constants for the half/single converter
// Holds the request codes and the stage payload types.
// ----------------------------------------------------------------------------
package hsfc_pkg;

  localparam logic ReqEncode = 1'b0;
  localparam logic ReqDecode = 1'b1;

  // Payload between the classify stage and the compute stage.
  typedef struct packed {
    logic        req;
    logic        sign;
    logic [7:0]  exp;      // single exponent, or half exponent zero-extended
    logic [10:0] man;      // top 11 single mantissa bits, or half mantissa
    logic        man_nz;   // full mantissa nonzero (NaN detection)
  } hsfc_cls_t;

  // Payload between the compute stage and the output stage.
  typedef struct packed {
    logic [31:0] base;     // result before rounding increment
    logic        inc;      // round-up bit to add
  } hsfc_cmp_t;

endpackage

### src/hsfc_stage.sv
// ----------------------------------------------------------------------------
// hsfc_stage: control of one elastic pipeline stage
// Holds the valid bit of a stage and gives the load enable for its data.
// ----------------------------------------------------------------------------
module hsfc_stage (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic valid_i,
  output logic ready_o,
  output logic valid_o,
  input  logic ready_i,
  output logic load_o
);

  logic valid_q;

  assign ready_o = !valid_q || ready_i;
  assign valid_o = valid_q;
  assign load_o  = ready_o && valid_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready_o) begin
      valid_q <= valid_i;
    end
  end

endmodule

### src/hsfc_classify.sv
// ----------------------------------------------------------------------------
// hsfc_classify: field extraction
// Splits the operand into sign, exponent and mantissa for either direction.
// ----------------------------------------------------------------------------
module hsfc_classify (
  input  logic                  req_i,
  input  logic [31:0]           value_i,
  output hsfc_pkg::hsfc_cls_t   cls_o
);
  import hsfc_pkg::*;

  always_comb begin
    cls_o.req = req_i;
    if (req_i == ReqEncode) begin
      cls_o.sign   = value_i[31];
      cls_o.exp    = value_i[30:23];
      cls_o.man    = value_i[22:12];
      cls_o.man_nz = |value_i[22:0];
    end else begin
      cls_o.sign   = value_i[15];
      cls_o.exp    = {3'b000, value_i[14:10]};
      cls_o.man    = {1'b0, value_i[9:0]};
      cls_o.man_nz = |value_i[9:0];
    end
  end

endmodule

### src/hsfc_compute.sv
// ----------------------------------------------------------------------------
// hsfc_compute: conversion core
// Builds the unrounded result and the rounding bit for both directions.
// ----------------------------------------------------------------------------
module hsfc_compute (
  input  hsfc_pkg::hsfc_cls_t cls_i,
  output hsfc_pkg::hsfc_cmp_t cmp_o
);
  import hsfc_pkg::*;

  logic [11:0] dm;
  logic [3:0]  sh;
  logic [11:0] dshift;
  logic [3:0]  lz;
  logic [9:0]  nm;
  logic [4:0]  hexp;

  always_comb begin
    dm     = {1'b1, cls_i.man};
    sh     = 4'(8'd113 - cls_i.exp);          // 1..10 in the denormal range
    dshift = dm >> sh;
    hexp   = 5'(cls_i.exp - 8'd112);
    lz     = 4'd9;
    for (int i = 0; i < 10; i++) begin
      if (cls_i.man[i]) lz = 4'(i);
    end
    nm     = 10'(cls_i.man[9:0] << (4'd10 - lz));
    cmp_o.base = '0;
    cmp_o.inc  = 1'b0;
    if (cls_i.req == ReqEncode) begin
      cmp_o.base[15] = cls_i.sign;
      if (cls_i.exp < 8'd103) begin
        cmp_o.base[14:0] = '0;
      end else if (cls_i.exp > 8'd142) begin
        cmp_o.base[14:10] = 5'h1f;
        cmp_o.base[0]     = (cls_i.exp == 8'hff) && cls_i.man_nz;
      end else if (cls_i.exp < 8'd113) begin
        cmp_o.base[10:0] = dshift[11:1];
        cmp_o.inc        = dshift[0];
      end else begin
        cmp_o.base[14:0] = {hexp, cls_i.man[10:1]};
        cmp_o.inc        = cls_i.man[0];
      end
    end else begin
      cmp_o.base[31] = cls_i.sign;
      if (cls_i.exp[4:0] == 5'd0) begin
        if (cls_i.man_nz) begin
          cmp_o.base[30:23] = 8'(lz) + 8'd103;
          cmp_o.base[22:13] = nm;
        end
      end else if (cls_i.exp[4:0] != 5'h1f) begin
        cmp_o.base[30:23] = cls_i.exp + 8'd112;
        cmp_o.base[22:13] = cls_i.man[9:0];
      end else if (!cls_i.man_nz) begin
        cmp_o.base[30:23] = 8'hff;
      end else begin
        cmp_o.base[30:22] = 9'h1ff;
      end
    end
  end

endmodule

### src/half_single_float_converter.sv
// ----------------------------------------------------------------------------
// half_single_float_converter: IEEE single <-> half bit pattern converter
// Three-stage pipeline: field split, conversion, rounding add.
// ----------------------------------------------------------------------------
// Channel   Dir  Fields (lowest bit first)
// s_axis    in   tuser = req_type (0 encode, 1 decode), tdata = value_in
// m_axis    out  tdata = result_bits
//
// One beat may enter every cycle while s_axis_tready is high; results leave in order.
// With no m_axis stall, three elastic stage registers give one beat per cycle.
// Reset clears only the stage valid bits; data registers are not reset.
// A stall on m_axis holds every full stage; no beat is lost or repeated.
// ----------------------------------------------------------------------------
module half_single_float_converter (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [31:0] s_axis_tdata,   // [31:0] value_in
  input  logic        s_axis_tuser,   // [0] req_type
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [31:0] m_axis_tdata    // [31:0] result_bits
);
  import hsfc_pkg::*;

  hsfc_cls_t cls_d, cls_q;
  hsfc_cmp_t cmp_d, cmp_q;
  logic      v1, r1, v2, r2;
  logic      ld1, ld2, ld3;
  logic [31:0] res_d, res_q;

  // Stage 1: split the operand into its fields.
  hsfc_classify u_cls (.req_i(s_axis_tuser), .value_i(s_axis_tdata), .cls_o(cls_d));

  hsfc_stage u_st1 (
    .clk_i, .rst_ni, .valid_i(s_axis_tvalid), .ready_o(s_axis_tready),
    .valid_o(v1), .ready_i(r1), .load_o(ld1)
  );

  // Stage 2: range selection, shifts and normalization.
  hsfc_compute u_cmp (.cls_i(cls_q), .cmp_o(cmp_d));

  hsfc_stage u_st2 (
    .clk_i, .rst_ni, .valid_i(v1), .ready_o(r1),
    .valid_o(v2), .ready_i(r2), .load_o(ld2)
  );

  // Stage 3: the rounding increment, which may carry into the exponent.
  // Encode results keep their upper half at zero since the half sum never
  // exceeds 0xFFFF.
  assign res_d = cmp_q.base + {31'd0, cmp_q.inc};

  hsfc_stage u_st3 (
    .clk_i, .rst_ni, .valid_i(v2), .ready_o(r2),
    .valid_o(m_axis_tvalid), .ready_i(m_axis_tready), .load_o(ld3)
  );

  // Stage data registers. Each loads only when its stage takes a new beat,
  // so a stalled stage keeps its contents.
  always_ff @(posedge clk_i) begin
    if (ld1) begin
      cls_q <= cls_d;
    end
    if (ld2) begin
      cmp_q <= cmp_d;
    end
    if (ld3) begin
      res_q <= res_d;
    end
  end

  assign m_axis_tdata = res_q;

  // A stalled output must hold its result.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("output beat changed during stall");

  // Only decode results may carry data in the upper half.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    v2 && cmp_q.inc |-> cmp_q.base[31:16] == 16'd0)
    else $error("rounding applied to a decode result");

  // Input is always accepted when the pipeline is drained downstream.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tready |-> s_axis_tready)
    else $error("pipeline stalled with free output");

endmodule
